[rtl/sha1_pkg.sv]
package sha1_pkg;

  localparam int DATA_W  = 8;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 3;
  localparam int LEN_W   = 64;
  localparam int NWORDS  = 5;
  localparam int BLK_W   = 512;
  localparam int POS_W   = 6;
  localparam int RND_W   = 7;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
  localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
  localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

  // element 0 is h0
  localparam logic [NWORDS-1:0][WORD_W-1:0] H_INIT = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [DATA_W-1:0] PAD_BYTE = 8'h80;

  localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;

  localparam logic [RND_W-1:0] RND_F1   = 7'd20;
  localparam logic [RND_W-1:0] RND_F2   = 7'd40;
  localparam logic [RND_W-1:0] RND_F3   = 7'd60;
  localparam logic [RND_W-1:0] RND_LAST = 7'd79;

  localparam logic [POS_W-1:0] POS_LAST = 6'd63;
  localparam logic [POS_W-1:0] POS_LEN  = 6'd56;

  localparam logic [LEN_W-1:0] BITS_PER_BYTE = 64'd8;

endpackage

[rtl/sha1_if.sv]
interface sha1_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [sha1_pkg::DATA_W-1:0]   data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface sha1_out_if;
  logic                          valid;
  logic                          ready;
  logic [sha1_pkg::WORD_W-1:0]   digest_word;
  logic [sha1_pkg::IDX_W-1:0]    word_index;
  logic                          last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha1_hash_engine_top.sv]
// Channel   Dir  Fields                                   Accepted when
// message   in   action, data_byte                        valid && ready
// digest    out  digest_word, word_index, last_word       valid && ready
//
// An absorb item shifts one byte in; the 64th byte of a block starts rounds 0 to 79
// on the single round unit, then the result is folded into the chain value.
// A finish item appends the 0x80 byte, then padding bytes go in one per cycle up
// to the block end; one or two blocks are compressed; then 5 digest items.
// Reset (rst, synchronous) loads the initial chain value and clears the count.
// The block is ready only in idle, not while padding, compressing or emitting; the
// digest stalls on digest.ready with its payload held.
module sha1_hash_engine_top (
  input  logic             clk,
  input  logic             rst,
  sha1_in_if.sink          message,
  sha1_out_if.source       digest
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                                         state;
  logic [sha1_pkg::POS_W-1:0]                         pos;
  logic [sha1_pkg::LEN_W-1:0]                         msg_bits;
  logic                                               fin;
  logic                                               long_pad;
  logic [sha1_pkg::RND_W-1:0]                         rnd;
  logic [sha1_pkg::IDX_W-1:0]                         oidx;
  logic [sha1_pkg::NWORDS-1:0][sha1_pkg::WORD_W-1:0]  h;
  logic [sha1_pkg::WORD_W-1:0]                        a, b, c, d, e;
  // 64-byte block as a shift line; byte 0 ends up in the top bits
  logic [sha1_pkg::BLK_W-1:0]                         blk;

  logic [sha1_pkg::WORD_W-1:0] w0, w2, w8, w13, wx, wnew, f, k, tmp;
  logic [sha1_pkg::DATA_W-1:0] pad_byte;

  assign w0  = blk[511:480];
  assign w2  = blk[447:416];
  assign w8  = blk[255:224];
  assign w13 = blk[95:64];
  assign wx  = w0 ^ w2 ^ w8 ^ w13;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd < sha1_pkg::RND_F1) begin
      f = (b & c) ^ (~b & d);
      k = sha1_pkg::K0;
    end else if (rnd < sha1_pkg::RND_F2) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (rnd < sha1_pkg::RND_F3) begin
      f = (b & c) ^ (b & d) ^ (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w0;

  // length bytes go in the last eight slots of the final block, MSB first
  always_comb begin
    if ((pos >= sha1_pkg::POS_LEN) && !long_pad) begin
      pad_byte = msg_bits[{~pos[2:0], 3'b000} +: sha1_pkg::DATA_W];
    end else begin
      pad_byte = '0;
    end
  end

  assign message.ready      = (state == S_IDLE);
  assign digest.valid       = (state == S_OUT);
  assign digest.digest_word = h[0];
  assign digest.word_index  = oidx;
  assign digest.last_word   = (oidx == sha1_pkg::LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      msg_bits <= '0;
      fin      <= 1'b0;
      long_pad <= 1'b0;
      rnd      <= '0;
      oidx     <= '0;
      h        <= sha1_pkg::H_INIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (message.valid) begin
            pos <= pos + 1'b1;
            if (message.action == sha1_pkg::ACT_ABSORB) begin
              blk      <= {blk[503:0], message.data_byte};
              msg_bits <= msg_bits + sha1_pkg::BITS_PER_BYTE;
            end else begin
              blk      <= {blk[503:0], sha1_pkg::PAD_BYTE};
              fin      <= 1'b1;
              long_pad <= (pos >= sha1_pkg::POS_LEN);
            end
            if (pos == sha1_pkg::POS_LAST) begin
              state <= S_ROUND;
              rnd   <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end else if (message.action == sha1_pkg::ACT_FINISH) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          blk <= {blk[503:0], pad_byte};
          pos <= pos + 1'b1;
          if (pos == sha1_pkg::POS_LAST) begin
            state <= S_ROUND;
            rnd   <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        S_ROUND: begin
          a   <= tmp;
          b   <= a;
          c   <= {b[1:0], b[31:2]};
          d   <= c;
          e   <= d;
          blk <= {blk[479:0], wnew};
          rnd <= rnd + 1'b1;
          if (rnd == sha1_pkg::RND_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          if (!fin) begin
            state <= S_IDLE;
          end else if (long_pad) begin
            // first padded block done; second block holds zeros and length
            long_pad <= 1'b0;
            state    <= S_PAD;
          end else begin
            oidx  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (digest.ready) begin
            oidx <= oidx + 1'b1;
            if (oidx == sha1_pkg::LAST_IDX) begin
              h        <= sha1_pkg::H_INIT;
              pos      <= '0;
              msg_bits <= '0;
              fin      <= 1'b0;
              state    <= S_IDLE;
            end else begin
              h <= {h[0], h[4:1]};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
